// ----- sv/hciupp_pkg.sv -----
// Shared types and constants for the HCI UART (H4) receive parser.
// Used by hciupp_framer and hci_uart_packet_parser_unit; no dependencies.
`default_nettype none

package hciupp_pkg;

   // H4 packet type indicators.
   localparam logic [7:0] TYPE_EVENT = 8'h04;
   localparam logic [7:0] TYPE_ACL   = 8'h02;

   // Context of the packet being received.
   localparam logic [1:0] KIND_NONE  = 2'd0;
   localparam logic [1:0] KIND_EVENT = 2'd1;
   localparam logic [1:0] KIND_ACL   = 2'd2;

   // Framing phase; encodings not listed here behave as idle.
   typedef enum logic [3:0] {
      PH_IDLE     = 4'd0,
      PH_EV_CODE  = 4'd1,
      PH_EV_LEN   = 4'd2,
      PH_EV_PARAM = 4'd3,
      PH_HDR0     = 4'd4,
      PH_HDR1     = 4'd5,
      PH_HDR2     = 4'd6,
      PH_HDR3     = 4'd7,
      PH_L2LEN0   = 4'd8,
      PH_L2LEN1   = 4'd9,
      PH_CID0     = 4'd10,
      PH_CID1     = 4'd11,
      PH_PAYLOAD  = 4'd12
   } parse_phase_type;

   // Classification of one received byte.
   typedef enum logic [3:0] {
      CLS_IGNORED   = 4'd0,
      CLS_EV_TYPE   = 4'd1,
      CLS_ACL_TYPE  = 4'd2,
      CLS_EV_CODE   = 4'd3,
      CLS_EV_LEN    = 4'd4,
      CLS_EV_PARAM  = 4'd5,
      CLS_ACL_HDR   = 4'd6,
      CLS_L2CAP_LEN = 4'd7,
      CLS_ACL_DATA  = 4'd8
   } byte_class_type;

   // One result item as produced by the framer.
   typedef struct packed {
      logic [7:0]     byte_value;
      byte_class_type byte_class;
      logic [15:0]    item_index;
      logic [7:0]     event_code;
      logic [1:0]     packet_kind;
      logic [15:0]    payload_length;
      logic           packet_end;
   } result_type;

endpackage

`default_nettype wire

// ----- sv/hci_uart_packet_parser_unit.sv -----
// Top level of the HCI UART (H4) receive parser: handshakes and result register.
// Depends on hciupp_pkg and hciupp_framer.
`default_nettype none

// Follows Bluetooth HCI H4 framing on a stream of received UART bytes and
// returns one result item for every byte: the byte, its class (packet type,
// event code or length, ACL header, L2CAP length, parameter or payload byte),
// its index inside the parameters or payload, the packet context and an end
// flag. Bytes of an unknown type seen between packets come back as ignored.
// The framer classifies each byte against the context registers and the
// result lands in the output register on the same edge, so a byte can be
// accepted every cycle unless req_stall is high. The result appears in the
// cycle after acceptance; req_stall is high only while a held result stalls.
module hci_uart_packet_parser_unit
   import hciupp_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [7:0]  req_rx_byte,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [7:0]       rsp_byte_value,
   output logic [3:0]       rsp_byte_class,
   output logic [15:0]      rsp_item_index,
   output logic [7:0]       rsp_event_code,
   output logic [1:0]       rsp_packet_kind,
   output logic [15:0]      rsp_payload_length,
   output logic             rsp_packet_end
);

   logic       valid_ff;
   result_type result_ff;
   result_type result;
   logic       accept;

   // An item is taken whenever the result register is free or being emptied.
   assign req_stall = valid_ff & rsp_stall;
   assign accept    = req_valid & ~req_stall;

   hciupp_framer u_framer (
      .clock   (clock),
      .reset   (reset),
      .advance (accept),
      .rx_byte (req_rx_byte),
      .result  (result)
   );

   // Result register valid flag.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (accept) begin
         valid_ff <= 1'b1;
      end else if (~rsp_stall) begin
         valid_ff <= 1'b0;
      end
   end

   // Result payload.
   always_ff @(posedge clock) begin
      if (accept) begin
         result_ff <= result;
      end
   end

   assign rsp_valid          = valid_ff;
   assign rsp_byte_value     = result_ff.byte_value;
   assign rsp_byte_class     = result_ff.byte_class;
   assign rsp_item_index     = result_ff.item_index;
   assign rsp_event_code     = result_ff.event_code;
   assign rsp_packet_kind    = result_ff.packet_kind;
   assign rsp_payload_length = result_ff.payload_length;
   assign rsp_packet_end     = result_ff.packet_end;

endmodule

`default_nettype wire

// ----- sv/hciupp_framer.sv -----
// H4 framing state machine: holds the packet context and classifies each byte.
// Depends on hciupp_pkg.
`default_nettype none

module hciupp_framer
   import hciupp_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       advance,
   input  wire logic [7:0] rx_byte,
   output result_type      result
);

   parse_phase_type phase_ff, phase_in;
   logic [15:0]     position_ff, position_in;
   logic [15:0]     length_ff, length_in;
   logic [7:0]      event_ff, event_in;
   logic [1:0]      kind_ff, kind_in;

   byte_class_type  byte_class;
   logic            last;
   logic [15:0]     index;
   logic [15:0]     position_next;

   assign position_next = position_ff + 16'd1;

   // Next framing phase.
   always_comb begin
      phase_in = phase_ff;
      case (phase_ff)
         PH_EV_CODE: phase_in = PH_EV_LEN;
         PH_EV_LEN: begin
            phase_in = (rx_byte == 8'd0) ? PH_IDLE : PH_EV_PARAM;
         end
         PH_EV_PARAM, PH_PAYLOAD: begin
            if (position_next == length_ff || length_ff == 16'd0) begin
               phase_in = PH_IDLE;
            end
         end
         PH_HDR0:   phase_in = PH_HDR1;
         PH_HDR1:   phase_in = PH_HDR2;
         PH_HDR2:   phase_in = PH_HDR3;
         PH_HDR3:   phase_in = PH_L2LEN0;
         PH_L2LEN0: phase_in = PH_L2LEN1;
         PH_L2LEN1: phase_in = PH_CID0;
         PH_CID0:   phase_in = PH_CID1;
         PH_CID1: begin
            phase_in = (length_ff == 16'd0) ? PH_IDLE : PH_PAYLOAD;
         end
         default: begin
            if (rx_byte == TYPE_EVENT) begin
               phase_in = PH_EV_CODE;
            end else if (rx_byte == TYPE_ACL) begin
               phase_in = PH_HDR0;
            end else begin
               phase_in = PH_IDLE;
            end
         end
      endcase
   end

   // Classification and context updates; the result shows the context after
   // this byte, and a completing byte then returns the context to reset.
   always_comb begin
      byte_class  = CLS_IGNORED;
      last        = 1'b0;
      index       = 16'd0;
      position_in = position_ff;
      length_in   = length_ff;
      event_in    = event_ff;
      kind_in     = kind_ff;
      case (phase_ff)
         PH_EV_CODE: begin
            byte_class = CLS_EV_CODE;
            event_in   = rx_byte;
         end
         PH_EV_LEN: begin
            byte_class  = CLS_EV_LEN;
            length_in   = {8'd0, rx_byte};
            position_in = 16'd0;
            last        = (rx_byte == 8'd0);
         end
         PH_EV_PARAM, PH_PAYLOAD: begin
            byte_class = (phase_ff == PH_EV_PARAM) ? CLS_EV_PARAM : CLS_ACL_DATA;
            index      = position_ff;
            if (position_next == length_ff || length_ff == 16'd0) begin
               last = 1'b1;
            end else begin
               position_in = position_next;
            end
         end
         PH_HDR0, PH_HDR1, PH_HDR2, PH_HDR3, PH_CID0: begin
            byte_class = CLS_ACL_HDR;
         end
         PH_L2LEN0: begin
            byte_class = CLS_L2CAP_LEN;
            length_in  = {8'd0, rx_byte};
         end
         PH_L2LEN1: begin
            byte_class = CLS_L2CAP_LEN;
            length_in  = length_ff + {rx_byte, 8'd0};
         end
         PH_CID1: begin
            byte_class  = CLS_ACL_HDR;
            position_in = 16'd0;
            last        = (length_ff == 16'd0);
         end
         default: begin
            position_in = 16'd0;
            length_in   = 16'd0;
            event_in    = 8'd0;
            kind_in     = KIND_NONE;
            if (rx_byte == TYPE_EVENT) begin
               byte_class = CLS_EV_TYPE;
               kind_in    = KIND_EVENT;
            end else if (rx_byte == TYPE_ACL) begin
               byte_class = CLS_ACL_TYPE;
               kind_in    = KIND_ACL;
            end
         end
      endcase
   end

   // Result fields for this byte.
   always_comb begin
      result.byte_value     = rx_byte;
      result.byte_class     = byte_class;
      result.item_index     = index;
      result.event_code     = (kind_in == KIND_EVENT) ? event_in : 8'd0;
      result.packet_kind    = kind_in;
      result.payload_length = length_in;
      result.packet_end     = last;
   end

   // Context registers; a completed packet returns them to reset values.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PH_IDLE;
         position_ff <= 16'd0;
         length_ff   <= 16'd0;
         event_ff    <= 8'd0;
         kind_ff     <= KIND_NONE;
      end else if (advance) begin
         if (last) begin
            phase_ff    <= PH_IDLE;
            position_ff <= 16'd0;
            length_ff   <= 16'd0;
            event_ff    <= 8'd0;
            kind_ff     <= KIND_NONE;
         end else begin
            phase_ff    <= phase_in;
            position_ff <= position_in;
            length_ff   <= length_in;
            event_ff    <= event_in;
            kind_ff     <= kind_in;
         end
      end
   end

endmodule

`default_nettype wire

// ----- tb/sv/tb_hci_uart_packet_parser_unit.sv -----
// Self-checking testbench for hci_uart_packet_parser_unit: a scoreboard class tracks
// H4 framing per received byte and checks every result item field by field.
// Depends on hciupp_pkg and the parser RTL; needs no files or arguments.
module tb_hci_uart_packet_parser_unit;
   import hciupp_pkg::*;

   // Tracks H4 framing for every accepted byte and checks the returned items.
   class h4_frame_scoreboard;
      parse_phase_type phase;
      logic [15:0]     position;
      logic [15:0]     length;
      logic [7:0]      code;
      logic [1:0]      kind;
      result_type      awaited_results[$];
      int              errors;
      int              checked;
      int              event_packets;
      int              acl_packets;
      int              ignored_bytes;

      function void clear_context();
         phase    = PH_IDLE;
         position = '0;
         length   = '0;
         code     = '0;
         kind     = KIND_NONE;
      endfunction

      // Works out the result item for one accepted byte and queues it.
      function byte_class_type frame_byte(input logic [7:0] rx);
         result_type     r;
         byte_class_type cls;
         logic [15:0]    idx;
         logic           last;
         cls  = CLS_IGNORED;
         idx  = '0;
         last = 1'b0;
         case (phase)
            PH_EV_CODE: begin
               cls   = CLS_EV_CODE;
               code  = rx;
               phase = PH_EV_LEN;
            end
            PH_EV_LEN: begin
               cls      = CLS_EV_LEN;
               length   = {8'h00, rx};
               position = '0;
               if (rx == 8'h00) last = 1'b1;
               else phase = PH_EV_PARAM;
            end
            PH_EV_PARAM, PH_PAYLOAD: begin
               cls = (phase == PH_EV_PARAM) ? CLS_EV_PARAM : CLS_ACL_DATA;
               idx = position;
               if (position + 16'd1 == length || length == 16'd0) last = 1'b1;
               else position = position + 16'd1;
            end
            PH_HDR0, PH_HDR1, PH_HDR2, PH_HDR3, PH_CID0: begin
               cls   = CLS_ACL_HDR;
               phase = parse_phase_type'(phase + 4'd1);
            end
            PH_L2LEN0: begin
               cls    = CLS_L2CAP_LEN;
               length = {8'h00, rx};
               phase  = PH_L2LEN1;
            end
            PH_L2LEN1: begin
               cls    = CLS_L2CAP_LEN;
               length = length + {rx, 8'h00};
               phase  = PH_CID0;
            end
            PH_CID1: begin
               cls      = CLS_ACL_HDR;
               position = '0;
               if (length == 16'd0) last = 1'b1;
               else phase = PH_PAYLOAD;
            end
            default: begin
               // Between packets only the two known type bytes open a packet.
               clear_context();
               if (rx == TYPE_EVENT) begin
                  cls   = CLS_EV_TYPE;
                  kind  = KIND_EVENT;
                  phase = PH_EV_CODE;
               end else if (rx == TYPE_ACL) begin
                  cls   = CLS_ACL_TYPE;
                  kind  = KIND_ACL;
                  phase = PH_HDR0;
               end else begin
                  ignored_bytes++;
               end
            end
         endcase

         r.byte_value     = rx;
         r.byte_class     = cls;
         r.item_index     = idx;
         r.event_code     = (kind == KIND_EVENT) ? code : 8'h00;
         r.packet_kind    = kind;
         r.payload_length = length;
         r.packet_end     = last;
         awaited_results.push_back(r);

         // A completed packet returns all context to its reset values.
         if (last) begin
            if (kind == KIND_EVENT) event_packets++;
            else acl_packets++;
            clear_context();
         end
         return cls;
      endfunction

      task report(input string what, input int got, input int want);
         $display("MISMATCH at result %0d: %s got 0x%0h, expected 0x%0h",
                  checked, what, got, want);
         errors++;
      endtask

      // Compares one returned item with the oldest awaited one.
      task check_result(input result_type got);
         result_type want;
         if (awaited_results.size() == 0) begin
            report("unexpected result, byte", got.byte_value, 0);
            return;
         end
         want = awaited_results.pop_front();
         if (got.byte_value !== want.byte_value)
            report("byte_value", got.byte_value, want.byte_value);
         if (got.byte_class !== want.byte_class)
            report("byte_class", got.byte_class, want.byte_class);
         if (got.item_index !== want.item_index)
            report("item_index", got.item_index, want.item_index);
         if (got.event_code !== want.event_code)
            report("event_code", got.event_code, want.event_code);
         if (got.packet_kind !== want.packet_kind)
            report("packet_kind", got.packet_kind, want.packet_kind);
         if (got.payload_length !== want.payload_length)
            report("payload_length", got.payload_length, want.payload_length);
         if (got.packet_end !== want.packet_end)
            report("packet_end", got.packet_end, want.packet_end);
         checked++;
      endtask
   endclass

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic [7:0]  req_rx_byte;
   logic        rsp_valid;
   logic        rsp_stall;
   logic [7:0]  rsp_byte_value;
   logic [3:0]  rsp_byte_class;
   logic [15:0] rsp_item_index;
   logic [7:0]  rsp_event_code;
   logic [1:0]  rsp_packet_kind;
   logic [15:0] rsp_payload_length;
   logic        rsp_packet_end;

   h4_frame_scoreboard sb;
   bit                 quiet;
   int                 framed_bytes;

   // Opening sequence: ignored bytes, zero and one length event packets,
   // ACL packets with a zero and a one byte L2CAP length.
   logic [7:0] opening [28] = '{
      8'hFF, 8'h00,
      8'h04, 8'h0F, 8'h00,
      8'h04, 8'h0E, 8'h01, 8'hA5,
      8'h02, 8'h01, 8'h20, 8'h04, 8'h00, 8'h00, 8'h00, 8'h40, 8'h00,
      8'h02, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h01, 8'h00, 8'hFF, 8'hFF, 8'h5A
   };

   hci_uart_packet_parser_unit dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_rx_byte        (req_rx_byte),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_byte_value     (rsp_byte_value),
      .rsp_byte_class     (rsp_byte_class),
      .rsp_item_index     (rsp_item_index),
      .rsp_event_code     (rsp_event_code),
      .rsp_packet_kind    (rsp_packet_kind),
      .rsp_payload_length (rsp_payload_length),
      .rsp_packet_end     (rsp_packet_end)
   );

   always #5 clock = ~clock;

   function int draw_wait();
      return quiet ? 0 : $urandom_range(0, 15);
   endfunction

   // Presents one byte after a random gap and holds it until accepted.
   task send_byte(input logic [7:0] rx);
      int gap;
      gap = draw_wait();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_rx_byte <= rx;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      if (sb.frame_byte(rx) != CLS_IGNORED) framed_bytes++;
   endtask

   task send_event(input logic [7:0] code, input int len);
      send_byte(TYPE_EVENT);
      send_byte(code);
      send_byte(len[7:0]);
      repeat (len) send_byte(8'($urandom));
   endtask

   task send_acl(input int len);
      send_byte(TYPE_ACL);
      repeat (4) send_byte(8'($urandom));
      send_byte(len[7:0]);
      send_byte(len[15:8]);
      repeat (2) send_byte(8'($urandom));
      repeat (len) send_byte(8'($urandom));
   endtask

   // Random bytes that keep any packet they open from growing too long.
   task send_noise_byte(input bit allow_type);
      logic [7:0] rx;
      rx = 8'($urandom);
      if (allow_type && $urandom_range(0, 7) == 0)
         rx = $urandom_range(0, 1) ? TYPE_EVENT : TYPE_ACL;
      if (sb.phase == PH_L2LEN1) rx = rx & 8'h01;
      if (sb.phase == PH_EV_LEN && $urandom_range(0, 7) != 0) rx = rx & 8'h1F;
      send_byte(rx);
   endtask

   // Sender holds off until every awaited result item has come back.
   task wait_for_results();
      req_valid <= 1'b0;
      @(posedge clock);
      while (sb.awaited_results.size() != 0) @(posedge clock);
   endtask

   function int short_length();
      return ($urandom_range(0, 5) == 0) ? 0 : $urandom_range(1, 12);
   endfunction

   function logic [7:0] pick_code();
      case ($urandom_range(0, 3))
         0: return 8'h03;
         1: return 8'h0E;
         2: return 8'h0F;
         default: return 8'($urandom);
      endcase
   endfunction

   // Result side: checks accepted items and stalls a random time after each.
   initial begin : result_side
      int         hold;
      result_type got;
      hold = 0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && !rsp_stall) begin
            got.byte_value     = rsp_byte_value;
            got.byte_class     = byte_class_type'(rsp_byte_class);
            got.item_index     = rsp_item_index;
            got.event_code     = rsp_event_code;
            got.packet_kind    = rsp_packet_kind;
            got.payload_length = rsp_payload_length;
            got.packet_end     = rsp_packet_end;
            sb.check_result(got);
            hold = draw_wait();
         end else if (hold > 0) begin
            hold--;
         end
         rsp_stall <= (hold != 0);
      end
   end

   // Guard against a hung handshake.
   initial begin : watchdog
      #4000000;
      $display("Verification failed");
      $finish;
   end

   // Stimulus, drain and verdict.
   initial begin : stimulus
      int pick;
      int waited;
      clock        = 1'b0;
      reset        = 1'b1;
      req_valid    = 1'b0;
      req_rx_byte  = 8'h00;
      rsp_stall    = 1'b0;
      quiet        = 1'b0;
      framed_bytes = 0;
      sb = new;
      sb.clear_context();
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      foreach (opening[i]) send_byte(opening[i]);
      wait_for_results();

      // Longest event parameter list and an L2CAP length above one byte.
      send_event(8'($urandom), 255);
      send_acl($urandom_range(256, 300));
      wait_for_results();

      // Mostly well-formed packets with random content, some noise.
      while (framed_bytes < 900) begin
         if ($urandom_range(0, 15) == 0) quiet = !quiet;
         pick = $urandom_range(0, 99);
         if (pick < 40) begin
            send_event(pick_code(), short_length());
         end else if (pick < 75) begin
            send_acl(short_length());
         end else if (pick < 96) begin
            repeat ($urandom_range(1, 6)) send_noise_byte(1'b1);
            while (sb.phase != PH_IDLE) send_noise_byte(1'b0);
         end else begin
            wait_for_results();
         end
      end
      req_valid <= 1'b0;
      quiet = 1'b0;

      waited = 0;
      while (sb.awaited_results.size() != 0 && waited < 2000) begin
         @(posedge clock);
         waited++;
      end
      repeat (8) @(posedge clock);
      if (sb.awaited_results.size() != 0)
         sb.report("items never returned, count", sb.awaited_results.size(), 0);

      $display("Checked %0d result items: %0d event and %0d ACL packets completed,",
               sb.checked, sb.event_packets, sb.acl_packets);
      $display("%0d bytes outside any packet ignored.", sb.ignored_bytes);
      if (sb.errors == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
